@@ rtl/mft_pkg.sv @@
// ---------------------------------------------------------------------------
// mft_pkg: shared definitions for the minimum-frequency key table
// Action and status codes, field widths, default sizes and the sequencer
// state type.
// ---------------------------------------------------------------------------
`default_nettype none

package mft_pkg;

    // Default table size and key width.
    localparam int unsigned DEF_CAPACITY = 64;
    localparam int unsigned DEF_KEY_BITS = 64;

    // Fixed port widths.
    localparam int unsigned ACT_W       = 3;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned FREQ_W      = 32;
    localparam int unsigned KEY_PORT_W  = 64;
    localparam int unsigned COUNT_OUT_W = 7;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_INSERT    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INCREMENT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SET       = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REMOVE    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_ADD       = 3'd4;
    localparam logic [ACT_W-1:0] ACT_GET       = 3'd5;
    localparam logic [ACT_W-1:0] ACT_QUERY_MIN = 3'd6;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd3;

    // Frequency constants.
    localparam logic [FREQ_W-1:0] FREQ_MAX    = 32'h7fff_ffff;
    localparam logic [FREQ_W-1:0] FREQ_ABSENT = 32'hffff_ffff;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

endpackage

`default_nettype wire

@@ rtl/mft_ram.sv @@
// ---------------------------------------------------------------------------
// mft_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module mft_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ rtl/min_frequency_key_table_unit.sv @@
// Operation: each word is matched by a linear scan of the filled entries that
// stops at a key hit, one entry RAM read per cycle; an unknown action code
// skips the scan, and a stalled output holds the result in the hand-over
// state. Throughput: one word at a time; in_stall stays high until the result
// moves to the output register. Reset clears only the control registers:
// sequencer state, scan state, fill count and handshake state.
// ---------------------------------------------------------------------------
// min_frequency_key_table_unit: least-frequently-used key table
// Keeps up to CAPACITY keys with a frequency and a selectable flag, applies
// one action per word and scans for the minimum selectable entry on query.
// ---------------------------------------------------------------------------
`default_nettype none

module min_frequency_key_table_unit #(
    parameter int unsigned CAPACITY = mft_pkg::DEF_CAPACITY,
    parameter int unsigned KEY_BITS = mft_pkg::DEF_KEY_BITS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [mft_pkg::ACT_W-1:0]            action,
    input  wire logic [mft_pkg::KEY_PORT_W-1:0]       key,
    input  wire logic signed [mft_pkg::FREQ_W-1:0]    value,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [mft_pkg::STATUS_W-1:0]              status,
    output logic signed [mft_pkg::FREQ_W-1:0]         frequency,
    output logic signed [mft_pkg::FREQ_W-1:0]         min_frequency,
    output logic [mft_pkg::KEY_PORT_W-1:0]            min_key,
    output logic [mft_pkg::COUNT_OUT_W-1:0]           entry_count
);

    localparam int unsigned IDX_W  = $clog2(CAPACITY);
    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
    localparam int unsigned FW     = mft_pkg::FREQ_W;
    localparam int unsigned WORD_W = KEY_BITS + 1 + FW;

    // Control registers.
    mft_pkg::state_t    state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic               found_reg, found_next;
    logic               min_found_reg, min_found_next;
    logic               out_valid_reg, out_valid_next;

    // Payload registers.
    logic [mft_pkg::ACT_W-1:0]    act_reg, act_next;
    logic [KEY_BITS-1:0]          key_reg, key_next;
    logic [FW-1:0]                value_reg, value_next;
    logic [IDX_W-1:0]             hit_slot_reg, hit_slot_next;
    logic [FW-1:0]                hit_freq_reg, hit_freq_next;
    logic                         hit_sel_reg, hit_sel_next;
    logic [IDX_W-1:0]             cmp_idx_reg, cmp_idx_next;
    logic [FW-1:0]                min_freq_reg, min_freq_next;
    logic [KEY_BITS-1:0]          min_key_reg, min_key_next;
    logic [mft_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [FW-1:0]                res_freq_reg, res_freq_next;
    logic [mft_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [FW-1:0]                out_freq_reg, out_freq_next;
    logic [FW-1:0]                out_min_freq_reg, out_min_freq_next;
    logic [KEY_BITS-1:0]          out_min_key_reg, out_min_key_next;
    logic [CNT_W-1:0]             out_count_reg, out_count_next;

    // RAM port signals.
    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic [WORD_W-1:0]   ram_wr_data;
    logic [IDX_W-1:0]    ram_rd_addr;
    logic [WORD_W-1:0]   ram_rd_data;
    logic [KEY_BITS-1:0] rd_key;
    logic                rd_sel;
    logic [FW-1:0]       rd_freq;

    // Update datapath.
    logic [FW-1:0]       base_freq;
    logic                base_sel;
    logic [FW-1:0]       new_freq;
    logic                new_sel;
    logic                key_match;
    logic                scan_more;

    // Entry store: {key, selectable, frequency}.
    mft_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_key  = ram_rd_data[WORD_W-1 -: KEY_BITS];
    assign rd_sel  = ram_rd_data[FW];
    assign rd_freq = ram_rd_data[FW-1:0];

    assign key_match   = cmp_valid_reg && (rd_key == key_reg);
    assign scan_more   = (scan_idx_reg < count_reg);
    assign ram_rd_addr = scan_idx_reg[IDX_W-1:0];

    // New frequency and flag from the entry found, or a fresh entry.
    always_comb
    begin
        base_freq = found_reg ? hit_freq_reg : '0;
        base_sel  = found_reg ? hit_sel_reg : (act_reg == mft_pkg::ACT_INSERT);
        new_freq  = base_freq;
        new_sel   = base_sel;
        unique case (act_reg)
            mft_pkg::ACT_INCREMENT:
            begin
                if (base_freq != mft_pkg::FREQ_MAX)
                begin
                    new_freq = base_freq + 1'b1;
                end
                new_sel = 1'b1;
            end
            mft_pkg::ACT_SET:
            begin
                new_freq = value_reg;
                new_sel  = 1'b1;
            end
            mft_pkg::ACT_REMOVE:
            begin
                new_sel = 1'b0;
            end
            mft_pkg::ACT_ADD:
            begin
                new_sel = 1'b1;
            end
            default:
            begin
                new_sel = base_sel;
            end
        endcase
    end

    // Sequencer: latch, scan, update, hand over.
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        scan_idx_next     = scan_idx_reg;
        cmp_valid_next    = 1'b0;
        cmp_idx_next      = scan_idx_reg[IDX_W-1:0];
        found_next        = found_reg;
        min_found_next    = min_found_reg;
        act_next          = act_reg;
        key_next          = key_reg;
        value_next        = value_reg;
        hit_slot_next     = hit_slot_reg;
        hit_freq_next     = hit_freq_reg;
        hit_sel_next      = hit_sel_reg;
        min_freq_next     = min_freq_reg;
        min_key_next      = min_key_reg;
        res_status_next   = res_status_reg;
        res_freq_next     = res_freq_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_status_next   = out_status_reg;
        out_freq_next     = out_freq_reg;
        out_min_freq_next = out_min_freq_reg;
        out_min_key_next  = out_min_key_reg;
        out_count_next    = out_count_reg;
        ram_wr_en         = 1'b0;
        ram_wr_addr       = found_reg ? hit_slot_reg : count_reg[IDX_W-1:0];
        ram_wr_data       = {key_reg, new_sel, new_freq};

        unique case (state_reg)
            mft_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next        = action;
                    key_next        = key[KEY_BITS-1:0];
                    value_next      = value;
                    scan_idx_next   = '0;
                    found_next      = 1'b0;
                    min_found_next  = 1'b0;
                    min_freq_next   = '0;
                    min_key_next    = '0;
                    res_status_next = mft_pkg::STATUS_OK;
                    res_freq_next   = (action == mft_pkg::ACT_QUERY_MIN) ?
                                      '0 : mft_pkg::FREQ_ABSENT;
                    if (action > mft_pkg::ACT_QUERY_MIN)
                    begin
                        state_next = mft_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = mft_pkg::ST_SCAN;
                    end
                end
            end

            mft_pkg::ST_SCAN:
            begin
                if (act_reg != mft_pkg::ACT_QUERY_MIN && key_match)
                begin
                    // Key found: keep its slot and contents.
                    found_next    = 1'b1;
                    hit_slot_next = cmp_idx_reg;
                    hit_freq_next = rd_freq;
                    hit_sel_next  = rd_sel;
                    state_next    = mft_pkg::ST_WRITE;
                end
                else
                begin
                    // Running minimum over selectable entries.
                    if (act_reg == mft_pkg::ACT_QUERY_MIN && cmp_valid_reg && rd_sel)
                    begin
                        if (!min_found_reg ||
                            ($signed(rd_freq) < $signed(min_freq_reg)) ||
                            (rd_freq == min_freq_reg && rd_key < min_key_reg))
                        begin
                            min_found_next = 1'b1;
                            min_freq_next  = rd_freq;
                            min_key_next   = rd_key;
                        end
                    end
                    if (scan_more)
                    begin
                        scan_idx_next  = scan_idx_reg + 1'b1;
                        cmp_valid_next = 1'b1;
                    end
                    else if (!cmp_valid_reg)
                    begin
                        if (act_reg == mft_pkg::ACT_QUERY_MIN)
                        begin
                            if (!min_found_reg)
                            begin
                                res_status_next = mft_pkg::STATUS_EMPTY;
                            end
                            state_next = mft_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = mft_pkg::ST_WRITE;
                        end
                    end
                end
            end

            mft_pkg::ST_WRITE:
            begin
                state_next = mft_pkg::ST_DONE;
                if (act_reg == mft_pkg::ACT_GET)
                begin
                    if (found_reg)
                    begin
                        res_freq_next = hit_freq_reg;
                    end
                    else
                    begin
                        res_status_next = mft_pkg::STATUS_NOT_FOUND;
                    end
                end
                else if (!found_reg && count_reg == CNT_W'(CAPACITY))
                begin
                    res_status_next = mft_pkg::STATUS_FULL;
                end
                else
                begin
                    ram_wr_en     = 1'b1;
                    res_freq_next = new_freq;
                    if (!found_reg)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end

            mft_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    out_status_next   = res_status_reg;
                    out_freq_next     = res_freq_reg;
                    out_min_freq_next = min_freq_reg;
                    out_min_key_next  = min_key_reg;
                    out_count_next    = count_reg;
                    state_next        = mft_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mft_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mft_pkg::ST_IDLE;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            min_found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            min_found_reg <= min_found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        act_reg          <= act_next;
        key_reg          <= key_next;
        value_reg        <= value_next;
        hit_slot_reg     <= hit_slot_next;
        hit_freq_reg     <= hit_freq_next;
        hit_sel_reg      <= hit_sel_next;
        cmp_idx_reg      <= cmp_idx_next;
        min_freq_reg     <= min_freq_next;
        min_key_reg      <= min_key_next;
        res_status_reg   <= res_status_next;
        res_freq_reg     <= res_freq_next;
        out_status_reg   <= out_status_next;
        out_freq_reg     <= out_freq_next;
        out_min_freq_reg <= out_min_freq_next;
        out_min_key_reg  <= out_min_key_next;
        out_count_reg    <= out_count_next;
    end

    // Ports.
    assign in_stall      = (state_reg != mft_pkg::ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign frequency     = out_freq_reg;
    assign min_frequency = out_min_freq_reg;
    assign min_key       = mft_pkg::KEY_PORT_W'(out_min_key_reg);
    assign entry_count   = mft_pkg::COUNT_OUT_W'(out_count_reg);

    // The fill count never exceeds the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    // The fill count only grows by one, and only in the update state.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |->
            (count_reg == $past(count_reg) + 1'b1) && $past(state_reg == mft_pkg::ST_WRITE))
        else $error("fill count changed outside an insertion");

    // A pending compare exists only while scanning.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> state_reg == mft_pkg::ST_SCAN)
        else $error("compare pending outside the scan");

    // A new result word comes only from the hand-over state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == mft_pkg::ST_DONE))
        else $error("result word raised outside hand-over");

endmodule

`default_nettype wire
